// ===== src/euler_zyx_rotation_matrix_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Euler ZYX rotation matrix unit
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ---------------------------------------------------------------------------
`ifndef EULER_ZYX_ROTATION_MATRIX_UNIT_MACROS_SVH
`define EULER_ZYX_ROTATION_MATRIX_UNIT_MACROS_SVH

// Same-cycle implication.
`define EZYX_ASSERT_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ezyx same-cycle check failed");

// Next-cycle implication.
`define EZYX_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ezyx next-cycle check failed");

`endif

// ===== src/ezyx_pkg.sv =====
// ---------------------------------------------------------------------------
// ezyx_pkg
// Shared widths, constants, types and the arctangent table of the unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ezyx_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int OUT_FRAC_BITS = 14;
    localparam int ATAN_ENTRIES  = 20;

    localparam int ANG_W = 16;
    localparam int XY_W  = 34;
    localparam int Z_W   = 35;
    localparam int Q_W   = 32;
    localparam int SUM_W = 33;
    localparam int OUT_W = 16;
    localparam int IDX_W = 5;
    localparam int ANG_SHIFT = 17;
    localparam int ONE_SHIFT = 30;

    localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;

    // One angle lane of a CORDIC cell.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg;
    } ezyx_lane_t;

    // Contents of one cell: valid flag and three lanes (x, y, z angles).
    typedef struct packed {
        logic              valid;
        ezyx_lane_t [2:0]  lane;
    } ezyx_stage_t;

    // Arctangent of 2^-i in Q30, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 35'sd843314857;
                5'd1:    v = 35'sd497837829;
                5'd2:    v = 35'sd263043837;
                5'd3:    v = 35'sd133525159;
                5'd4:    v = 35'sd67021687;
                5'd5:    v = 35'sd33543516;
                5'd6:    v = 35'sd16775851;
                5'd7:    v = 35'sd8388437;
                5'd8:    v = 35'sd4194283;
                5'd9:    v = 35'sd2097149;
                5'd10:   v = 35'sd1048576;
                5'd11:   v = 35'sd524288;
                5'd12:   v = 35'sd262144;
                5'd13:   v = 35'sd131072;
                5'd14:   v = 35'sd65536;
                5'd15:   v = 35'sd32768;
                5'd16:   v = 35'sd16384;
                5'd17:   v = 35'sd8192;
                5'd18:   v = 35'sd4096;
                5'd19:   v = 35'sd2048;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Q30 product, floor of the full product shifted right by 30.
    function automatic logic signed [Q_W-1:0] mul_q30(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        begin
            p = a * b;
            return Q_W'(p >>> ONE_SHIFT);
        end
    endfunction

endpackage

// ===== src/ezyx_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// ezyx_cordic_cell
// One rotation-mode CORDIC iteration for three angle lanes, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ezyx_cordic_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [ezyx_pkg::IDX_W-1:0]      stage_idx,
    input  ezyx_pkg::ezyx_stage_t           cell_in,
    output ezyx_pkg::ezyx_stage_t           cell_out
);

    ezyx_pkg::ezyx_stage_t       stage_next;
    logic                        valid_reg;
    ezyx_pkg::ezyx_lane_t [2:0]  lane_reg;

    // Rotate each lane toward zero residual angle.
    always_comb
    begin
        logic signed [ezyx_pkg::XY_W-1:0] xs;
        logic signed [ezyx_pkg::XY_W-1:0] ys;
        logic signed [ezyx_pkg::Z_W-1:0]  at;
        stage_next       = cell_in;
        at               = ezyx_pkg::atan_q30(stage_idx);
        for (int k = 0; k < 3; k++)
        begin
            xs = cell_in.lane[k].x >>> stage_idx;
            ys = cell_in.lane[k].y >>> stage_idx;
            if (cell_in.lane[k].z >= 0)
            begin
                stage_next.lane[k].x = cell_in.lane[k].x - ys;
                stage_next.lane[k].y = cell_in.lane[k].y + xs;
                stage_next.lane[k].z = cell_in.lane[k].z - at;
            end
            else
            begin
                stage_next.lane[k].x = cell_in.lane[k].x + ys;
                stage_next.lane[k].y = cell_in.lane[k].y - xs;
                stage_next.lane[k].z = cell_in.lane[k].z + at;
            end
        end
    end

    // Valid flag is reset; lane data is plain payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= stage_next.lane;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.lane  = lane_reg;

endmodule

// ===== src/ezyx_matrix.sv =====
// ---------------------------------------------------------------------------
// ezyx_matrix
// Forms the nine matrix entries from the sines and cosines, with rounding
// and saturation, over four registered steps; the last is the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ezyx_matrix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  ezyx_pkg::ezyx_stage_t       sc_in,
    output logic                        out_valid,
    output logic [9*ezyx_pkg::OUT_W-1:0] out_data
);

    localparam int QW = ezyx_pkg::Q_W;
    localparam int SW = ezyx_pkg::SUM_W;
    localparam int RND_SHIFT = 30 - ezyx_pkg::OUT_FRAC_BITS;
    localparam logic signed [SW-1:0] RND_HALF = SW'(64'sd1 <<< (RND_SHIFT - 1));
    localparam logic signed [SW-1:0] LIM      = SW'(64'sd1 <<< ezyx_pkg::OUT_FRAC_BITS);

    logic                 va_reg, vb_reg, vc_reg, vd_reg;
    logic signed [QW-1:0] s_reg [3];
    logic signed [QW-1:0] c_reg [3];
    logic signed [QW-1:0] sb_reg [3];
    logic signed [QW-1:0] cb_reg [3];
    logic signed [QW-1:0] czsy_reg, szsy_reg;
    logic signed [QW-1:0] p_reg [12];
    logic signed [QW-1:0] ny_reg;
    logic [9*ezyx_pkg::OUT_W-1:0] data_reg;
    logic [9*ezyx_pkg::OUT_W-1:0] data_next;

    // Round half up and saturate one entry.
    function automatic logic [ezyx_pkg::OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        begin
            r = (v + RND_HALF) >>> RND_SHIFT;
            if (r > LIM)
                r = LIM;
            if (r < -LIM)
                r = -LIM;
            return r[ezyx_pkg::OUT_W-1:0];
        end
    endfunction

    // Valid flags for the four steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= sc_in.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Final entries: sums, rounding and saturation.
    always_comb
    begin
        data_next = '0;
        data_next[0*16 +: 16] = to_out(SW'(p_reg[0]));
        data_next[1*16 +: 16] = to_out(SW'(p_reg[1]) - SW'(p_reg[2]));
        data_next[2*16 +: 16] = to_out(SW'(p_reg[3]) + SW'(p_reg[4]));
        data_next[3*16 +: 16] = to_out(SW'(p_reg[5]));
        data_next[4*16 +: 16] = to_out(SW'(p_reg[6]) + SW'(p_reg[7]));
        data_next[5*16 +: 16] = to_out(SW'(p_reg[8]) - SW'(p_reg[9]));
        data_next[6*16 +: 16] = to_out(-SW'(ny_reg));
        data_next[7*16 +: 16] = to_out(SW'(p_reg[10]));
        data_next[8*16 +: 16] = to_out(SW'(p_reg[11]));
    end

    // Payload steps: sign fix, first products, remaining products, entries.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (sc_in.lane[k].neg)
                begin
                    c_reg[k] <= QW'(-sc_in.lane[k].x);
                    s_reg[k] <= QW'(-sc_in.lane[k].y);
                end
                else
                begin
                    c_reg[k] <= QW'(sc_in.lane[k].x);
                    s_reg[k] <= QW'(sc_in.lane[k].y);
                end
                sb_reg[k] <= s_reg[k];
                cb_reg[k] <= c_reg[k];
            end
            czsy_reg <= ezyx_pkg::mul_q30(c_reg[2], s_reg[1]);
            szsy_reg <= ezyx_pkg::mul_q30(s_reg[2], s_reg[1]);
            p_reg[0]  <= ezyx_pkg::mul_q30(cb_reg[2], cb_reg[1]);
            p_reg[1]  <= ezyx_pkg::mul_q30(czsy_reg, sb_reg[0]);
            p_reg[2]  <= ezyx_pkg::mul_q30(sb_reg[2], cb_reg[0]);
            p_reg[3]  <= ezyx_pkg::mul_q30(czsy_reg, cb_reg[0]);
            p_reg[4]  <= ezyx_pkg::mul_q30(sb_reg[2], sb_reg[0]);
            p_reg[5]  <= ezyx_pkg::mul_q30(sb_reg[2], cb_reg[1]);
            p_reg[6]  <= ezyx_pkg::mul_q30(szsy_reg, sb_reg[0]);
            p_reg[7]  <= ezyx_pkg::mul_q30(cb_reg[2], cb_reg[0]);
            p_reg[8]  <= ezyx_pkg::mul_q30(szsy_reg, cb_reg[0]);
            p_reg[9]  <= ezyx_pkg::mul_q30(cb_reg[2], sb_reg[0]);
            p_reg[10] <= ezyx_pkg::mul_q30(cb_reg[1], sb_reg[0]);
            p_reg[11] <= ezyx_pkg::mul_q30(cb_reg[1], cb_reg[0]);
            ny_reg    <= sb_reg[1];
            data_reg  <= data_next;
        end
    end

    assign out_valid = vd_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/euler_zyx_rotation_matrix_unit.sv =====
// ---------------------------------------------------------------------------
// euler_zyx_rotation_matrix_unit
// Rotation matrix Rz*Ry*Rx from three Euler angles via pipelined CORDIC.
// ---------------------------------------------------------------------------
// The unit accepts one transaction of three Q3.13 angles per cycle while the
// pipeline advances, and returns the nine Q2.14 entries of Rz*Ry*Rx, each
// rounded and saturated to plus or minus 1.0. It has one CORDIC cell per
// iteration, each rotating all three angles, then four registered steps for
// the products and the output. The whole pipeline advances whenever the
// output register is empty or being taken.
`timescale 1ns / 1ps
`include "euler_zyx_rotation_matrix_unit_macros.svh"

module euler_zyx_rotation_matrix_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // angle_x, angle_y, angle_z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata    // m_r0_c0 .. m_r2_c2, row major
);

    localparam int NST = ezyx_pkg::CORDIC_STAGES;

    logic                  adv;
    ezyx_pkg::ezyx_stage_t chain [NST+1];

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Widen each angle to Q30 and fold it into plus or minus pi/2.
    always_comb
    begin
        logic signed [ezyx_pkg::Z_W-1:0] z;
        chain[0].valid = s_axis_tvalid;
        for (int k = 0; k < 3; k++)
        begin
            z = ezyx_pkg::Z_W'($signed(s_axis_tdata[k*16 +: 16])) <<< ezyx_pkg::ANG_SHIFT;
            chain[0].lane[k].x   = ezyx_pkg::GAIN_Q30;
            chain[0].lane[k].y   = '0;
            chain[0].lane[k].neg = 1'b0;
            if (z > ezyx_pkg::HALF_PI_Q30)
            begin
                chain[0].lane[k].z   = z - ezyx_pkg::PI_Q30;
                chain[0].lane[k].neg = 1'b1;
            end
            else if (z < -ezyx_pkg::HALF_PI_Q30)
            begin
                chain[0].lane[k].z   = z + ezyx_pkg::PI_Q30;
                chain[0].lane[k].neg = 1'b1;
            end
            else
            begin
                chain[0].lane[k].z = z;
            end
        end
    end

    // Row of CORDIC cells.
    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        ezyx_cordic_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .stage_idx (ezyx_pkg::IDX_W'(g)),
            .cell_in   (chain[g]),
            .cell_out  (chain[g+1])
        );
    end

    // Products, rounding and output register.
    ezyx_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .sc_in     (chain[NST]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    // A stalled output must hold off new input.
    `EZYX_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // A finished CORDIC item moves on through the matrix steps to the output; first step check.
    `EZYX_ASSERT_NEXT(a_last_cell_moves, chain[NST].valid && adv && m_axis_tready, u_matrix.va_reg || !adv)
    // The first and last saturated entries stay within plus or minus one.
    `EZYX_ASSERT_IMP(a_entry_range, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd16384) && ($signed(m_axis_tdata[15:0]) >= -16'sd16384) && ($signed(m_axis_tdata[143:128]) <= 16'sd16384) && ($signed(m_axis_tdata[143:128]) >= -16'sd16384))

endmodule
